// File: src/hte_pkg.sv
// ---------------------------------------------------------------------------
// hte_pkg
// Shared types, constants and tag-name tables for the html text extractor.
// ---------------------------------------------------------------------------
package hte_pkg;

  localparam int unsigned DATA_W      = 8;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned MAX_BYTES   = 4;
  localparam int unsigned NAME_COUNT  = 14;
  localparam int unsigned NAME_CHARS  = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_CAPACITY = 1'b0,
    REG_MAX_CHARS       = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ACT_SCRIPT_ON,
    ACT_STYLE_ON,
    ACT_SCRIPT_OFF,
    ACT_STYLE_OFF,
    ACT_BLOCK
  } tag_act_e;

  localparam logic [DATA_W-1:0] CH_LT    = 8'h3C;
  localparam logic [DATA_W-1:0] CH_GT    = 8'h3E;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;

  // names are right-aligned, first character in the highest filled byte
  localparam logic [8*NAME_CHARS-1:0] NAME_STR [NAME_COUNT] = '{
    "script", "style", "/script", "/style", "p>", "/p>", "div>", "/div>",
    "blockquote>", "/blockquote>", "br>", "br/>", "br />", "/li>"
  };

  localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
    4'd6, 4'd5, 4'd7, 4'd6, 4'd2, 4'd3, 4'd4, 4'd5,
    4'd11, 4'd12, 4'd3, 4'd4, 4'd5, 4'd4
  };

  // script and style names need one more byte after the name
  localparam logic NAME_EXTRA [NAME_COUNT] = '{
    1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  localparam tag_act_e NAME_ACT [NAME_COUNT] = '{
    ACT_SCRIPT_ON, ACT_STYLE_ON, ACT_SCRIPT_OFF, ACT_STYLE_OFF,
    ACT_BLOCK, ACT_BLOCK, ACT_BLOCK, ACT_BLOCK, ACT_BLOCK,
    ACT_BLOCK, ACT_BLOCK, ACT_BLOCK, ACT_BLOCK, ACT_BLOCK
  };

  // utf-8 character length from its lead byte
  function automatic logic [2:0] char_len(input logic [DATA_W-1:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // everything one input byte produces: optional space, raw bytes, end mark
  typedef struct packed {
    logic                             space;
    logic [2:0]                       n_bytes;
    logic [MAX_BYTES-1:0][DATA_W-1:0] bytes;
    logic                             done;
    logic [LEN_W-1:0]                 total;
  } cmd_t;

endpackage

// File: src/hte_front.sv
// ---------------------------------------------------------------------------
// hte_front
// Accepts document bytes, runs the tag matcher, block and whitespace tracking,
// utf-8 gathering and limits, and posts one command per producing byte.
// ---------------------------------------------------------------------------
module hte_front #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned DEPTH_MAX   = 255
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [hte_pkg::DATA_W-1:0]         byte_i,
  input  logic                               last_i,
  input  logic                               cfg_we_i,
  input  logic [hte_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hte_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               full_i,
  output logic                               push_o,
  output hte_pkg::cmd_t                      cmd_o
);
  import hte_pkg::*;

  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned DW   = (DEPTH_MAX > 1) ? $clog2(DEPTH_MAX + 1) : 1;
  localparam int unsigned CMPW = ((CW > LEN_W) ? CW : LEN_W) + 1;
  localparam logic [DW-1:0] DepthTop = DW'(DEPTH_MAX);

  logic [DW-1:0]             depth_q, depth_d;
  logic                      script_q, script_d, style_q, style_d;
  logic                      lws_q, lws_d, pend_q, pend_d, halted_q, halted_d;
  logic [NAME_COUNT-1:0]     mask_q, mask_d;
  logic [3:0]                pos_q, pos_d;
  logic [CW-1:0]             cc_q, cc_d, bc_q, bc_d;
  logic [1:0]                rem_q, rem_d;
  logic [2:0]                fill_q, fill_d;
  logic [DATA_W-1:0]         buf_q [MAX_BYTES];
  logic [DATA_W-1:0]         buf_d [MAX_BYTES];
  logic [CFG_DATA_W-1:0]     cap_q, cap_d, maxc_q, maxc_d;

  logic                      accept;
  logic [LEN_W-1:0]          limit;
  logic                      at_limit;
  logic [DATA_W-1:0]         fold;
  logic [3:0]                pos_n;
  logic [NAME_COUNT-1:0]     keep;
  logic                      any_hit;
  tag_act_e                  hit_act;
  logic [2:0]                clen;
  cmd_t                      cmd;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;
  assign limit   = (cap_q != '0) ? cap_q - LEN_W'(1) : '0;
  assign at_limit = (CMPW'(bc_q) >= CMPW'(limit)) ||
                    ((maxc_q != '0) && (CMPW'(cc_q) >= CMPW'(maxc_q)));
  assign fold  = (byte_i >= 8'h41 && byte_i <= 8'h5A) ? byte_i + 8'h20 : byte_i;
  assign pos_n = pos_q + 4'd1;
  assign clen  = char_len(byte_i);

  // all candidate names compared in parallel, highest index wins a hit
  always_comb begin
    logic       ok;
    logic [3:0] sel;
    keep    = '0;
    any_hit = 1'b0;
    hit_act = ACT_BLOCK;
    for (int i = 0; i < NAME_COUNT; i++) begin
      sel = NAME_LEN[i] - pos_n;
      ok  = (pos_n <= NAME_LEN[i]) ? (fold == NAME_STR[i][{sel, 3'b000} +: DATA_W]) : 1'b1;
      if (mask_q[i] && ok) begin
        if (pos_n == NAME_LEN[i] + 4'(NAME_EXTRA[i])) begin
          any_hit = 1'b1;
          hit_act = NAME_ACT[i];
        end else begin
          keep[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    depth_d  = depth_q;
    script_d = script_q;
    style_d  = style_q;
    lws_d    = lws_q;
    pend_d   = pend_q;
    halted_d = halted_q;
    mask_d   = mask_q;
    pos_d    = pos_q;
    cc_d     = cc_q;
    bc_d     = bc_q;
    rem_d    = rem_q;
    fill_d   = fill_q;
    buf_d    = buf_q;
    cap_d    = cap_q;
    maxc_d   = maxc_q;
    cmd      = '0;

    if (cfg_we_i) begin
      if (cfg_idx_i == REG_OUTPUT_CAPACITY) begin
        cap_d = cfg_wdata_i;
      end else if (cfg_idx_i == REG_MAX_CHARS) begin
        maxc_d = cfg_wdata_i;
      end
    end

    if (accept) begin
      if (halted_q) begin
        // bytes ignored until the end of the document
      end else if (rem_q != '0) begin
        buf_d[fill_q[1:0]] = byte_i;
        fill_d = fill_q + 3'd1;
        rem_d  = rem_q - 2'd1;
        if (rem_d == '0) begin
          cmd.space   = pend_q;
          pend_d      = 1'b0;
          cmd.n_bytes = fill_d;
          for (int j = 0; j < MAX_BYTES; j++) begin
            cmd.bytes[j] = buf_d[j];
          end
          bc_d   = bc_q + CW'(fill_d);
          cc_d   = cc_q + CW'(1);
          fill_d = '0;
        end else if (last_i) begin
          halted_d = 1'b1;
        end
      end else if (at_limit) begin
        halted_d = 1'b1;
      end else begin
        if (mask_q != '0) begin
          pos_d  = pos_n;
          mask_d = any_hit ? '0 : keep;
          if (any_hit) begin
            case (hit_act)
              ACT_SCRIPT_ON:  script_d = 1'b1;
              ACT_STYLE_ON:   style_d  = 1'b1;
              ACT_SCRIPT_OFF: script_d = 1'b0;
              ACT_STYLE_OFF:  style_d  = 1'b0;
              ACT_BLOCK: begin
                if (!lws_d) begin
                  pend_d = 1'b1;
                  lws_d  = 1'b1;
                  bc_d   = bc_d + CW'(1);
                  cc_d   = cc_d + CW'(1);
                end
              end
              default: ;
            endcase
          end
        end

        if (byte_i == CH_LT) begin
          if (depth_q != DepthTop) depth_d = depth_q + DW'(1);
          mask_d = '1;
          pos_d  = '0;
        end else if (byte_i == CH_GT) begin
          if (depth_q != '0) depth_d = depth_q - DW'(1);
        end else if (depth_q != '0 || script_d || style_d) begin
          // inside markup, script or style
        end else if (byte_i == CH_SPACE || byte_i == CH_TAB ||
                     byte_i == CH_CR || byte_i == CH_LF) begin
          if (!lws_d) begin
            pend_d = 1'b1;
            lws_d  = 1'b1;
            bc_d   = bc_d + CW'(1);
            cc_d   = cc_d + CW'(1);
          end
        end else begin
          lws_d = 1'b0;
          if (CMPW'(bc_d) + CMPW'(clen) > CMPW'(limit)) begin
            halted_d = 1'b1;
          end else if (clen == 3'd1) begin
            cmd.space    = pend_d;
            pend_d       = 1'b0;
            cmd.n_bytes  = 3'd1;
            cmd.bytes[0] = byte_i;
            bc_d = bc_d + CW'(1);
            cc_d = cc_d + CW'(1);
          end else if (last_i) begin
            halted_d = 1'b1;
          end else begin
            buf_d[0] = byte_i;
            fill_d   = 3'd1;
            rem_d    = 2'(clen - 3'd1);
          end
        end
      end

      if (last_i) begin
        cmd.done  = 1'b1;
        // a held-back space at the end is never written
        cmd.total = LEN_W'(bc_d) - LEN_W'(pend_d);
        depth_d  = '0;
        script_d = 1'b0;
        style_d  = 1'b0;
        lws_d    = 1'b1;
        pend_d   = 1'b0;
        halted_d = 1'b0;
        mask_d   = '0;
        pos_d    = '0;
        cc_d     = '0;
        bc_d     = '0;
        rem_d    = '0;
        fill_d   = '0;
      end
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && (cmd.space || cmd.n_bytes != '0 || cmd.done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      script_q <= 1'b0;
      style_q  <= 1'b0;
      lws_q    <= 1'b1;
      pend_q   <= 1'b0;
      halted_q <= 1'b0;
      mask_q   <= '0;
      pos_q    <= '0;
      cc_q     <= '0;
      bc_q     <= '0;
      rem_q    <= '0;
      fill_q   <= '0;
      cap_q    <= 16'hFFFF;
      maxc_q   <= '0;
    end else begin
      depth_q  <= depth_d;
      script_q <= script_d;
      style_q  <= style_d;
      lws_q    <= lws_d;
      pend_q   <= pend_d;
      halted_q <= halted_d;
      mask_q   <= mask_d;
      pos_q    <= pos_d;
      cc_q     <= cc_d;
      bc_q     <= bc_d;
      rem_q    <= rem_d;
      fill_q   <= fill_d;
      cap_q    <= cap_d;
      maxc_q   <= maxc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

// File: src/hte_queue.sv
// ---------------------------------------------------------------------------
// hte_queue
// Small command queue between the byte classifier and the output sequencer.
// ---------------------------------------------------------------------------
module hte_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hte_pkg::cmd_t entry_i,
  output logic          full_o,
  output logic          valid_o,
  output hte_pkg::cmd_t entry_o,
  input  logic          pop_i
);
  import hte_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_pop;

  assign full_o  = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) wptr_d = wptr_q + QPTR_W'(1);
    if (do_pop) rptr_d = rptr_q + QPTR_W'(1);
    if (push_i && !do_pop) begin
      count_d = count_q + (QPTR_W + 1)'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= entry_i;
  end

endmodule

// File: src/hte_back.sv
// ---------------------------------------------------------------------------
// hte_back
// Expands the head command into output beats: space, raw bytes, end mark.
// ---------------------------------------------------------------------------
module hte_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  hte_pkg::cmd_t              entry_i,
  output logic                       pop_o,
  output logic                       m_valid_o,
  input  logic                       m_ready_i,
  output logic [hte_pkg::DATA_W-1:0] byte_o,
  output logic                       done_o,
  output logic [hte_pkg::LEN_W-1:0]  length_o,
  output logic                       run_end_o
);
  import hte_pkg::*;

  logic [2:0] k_q, k_d;
  logic [2:0] count;
  logic [2:0] j;
  logic       is_space, is_byte, beat;

  assign count    = {2'b00, entry_i.space} + entry_i.n_bytes + {2'b00, entry_i.done};
  assign is_space = entry_i.space && (k_q == '0);
  assign j        = k_q - {2'b00, entry_i.space};
  assign is_byte  = !is_space && (j < entry_i.n_bytes);

  assign m_valid_o = valid_i;
  assign done_o    = !is_space && !is_byte;
  assign byte_o    = is_space ? CH_SPACE : (is_byte ? entry_i.bytes[j[1:0]] : '0);
  assign length_o  = done_o ? entry_i.total : '0;
  assign run_end_o = (k_q == count - 3'd1);

  assign beat  = valid_i && m_ready_i;
  assign pop_o = beat && run_end_o;

  always_comb begin
    k_d = k_q;
    if (beat) k_d = run_end_o ? '0 : k_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

endmodule

// File: src/html_text_extractor_core.sv
// ---------------------------------------------------------------------------
// html_text_extractor_core
// Strips markup from an html byte stream and emits plain text bytes, ending
// each document with a beat that carries the text length.
// ---------------------------------------------------------------------------
//  channel   | direction | tdata                              | tuser   | tlast
//  s_axis    | in        | [7:0] in_byte                      | -       | in_last
//  m_axis    | out       | [7:0] out_byte, [23:8] text_length | is_done | run_end
//  cfg       | in        | cfg_idx_i 0 output_capacity, 1 max_chars, 16-bit data
//
//  the front takes one input beat per cycle while the command queue has room
//  a byte gives 0 to 6 output beats, sent one per ready cycle from the queue head,
//  so the sustained rate is one input beat per cycle unless output beats pile up
//  output stalls fill the 4-entry queue, which then stalls the input side
//  reset clears all document state and loads capacity 65535, char limit 0
// ---------------------------------------------------------------------------
module html_text_extractor_core #(
  parameter int unsigned COUNT_WIDTH = 16,
  parameter int unsigned DEPTH_MAX   = 255
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [7:0]                           s_axis_tdata,  // [7:0] in_byte
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // [7:0] out_byte, [23:8] text_length
  output logic                                 m_axis_tuser,  // [0] is_done
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_we_i,
  input  logic [hte_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [hte_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);
  import hte_pkg::*;

  cmd_t              push_cmd, head_cmd;
  logic              push, full, head_valid, pop;
  logic [DATA_W-1:0] out_byte;
  logic [LEN_W-1:0]  out_len;

  hte_front #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .DEPTH_MAX  (DEPTH_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s_axis_tvalid),
    .ready_o    (s_axis_tready),
    .byte_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  hte_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_cmd),
    .full_o (full),
    .valid_o(head_valid),
    .entry_o(head_cmd),
    .pop_i  (pop)
  );

  hte_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (head_valid),
    .entry_i  (head_cmd),
    .pop_o    (pop),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .byte_o   (out_byte),
    .done_o   (m_axis_tuser),
    .length_o (out_len),
    .run_end_o(m_axis_tlast)
  );

  assign m_axis_tdata = {out_len, out_byte};

endmodule

// File: src/hte_checker.sv
// ---------------------------------------------------------------------------
// hte_checker
// Port-level checks on the output stream of the html text extractor.
// ---------------------------------------------------------------------------
module hte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // the end-of-document beat always closes its run
  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("end beat without tlast");

  // text beats carry no length
  a_text_no_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[23:8] == 16'h0000)
    else $error("text beat with nonzero length");

  // end beat carries a zero byte
  a_done_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'h00)
    else $error("end beat with nonzero byte");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled output beat changed");

endmodule

bind html_text_extractor_core hte_checker u_hte_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
